### rtl/bed_pkg.sv
// Shared constants, handshake structs and the hex digit helper for the
// backslash escape decoder. No dependencies.
package bed_pkg;

  localparam int BYTE_W         = 8;
  localparam int MAX_OUT_W      = 17;
  localparam int COUNT_BITS_DEF = 17;
  localparam int HOLD_DEPTH     = 5;
  localparam int HOLD_CNT_W     = 3;
  localparam int LIST_DEPTH     = HOLD_DEPTH + 1;
  localparam int LIST_CNT_W     = 3;

  localparam logic [MAX_OUT_W-1:0] MAX_OUT_RESET = 17'h10000;

  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_X      = 8'h78;
  localparam logic [BYTE_W-1:0] CH_U      = 8'h75;

  // position after which each escape kind completes
  localparam logic [HOLD_CNT_W-1:0] X_DONE_POS = 3'd3;
  localparam logic [HOLD_CNT_W-1:0] U_DONE_POS = 3'd5;

  typedef struct packed {
    logic load;  // accept an input word and build its result list
    logic pop;   // move the head of the result list to the output register
    logic take;  // output register handed off downstream
  } bed_cmd_t;

  typedef struct packed {
    logic list_nz;   // result list holds at least one word
    logic list_one;  // result list holds exactly one word
    logic load_nz;   // the word at the input would produce a result
    logic out_full;  // output register holds a word
  } bed_stat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              valid;
  } bed_entry_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

### rtl/bed_if.sv
// Valid/ready channel interfaces for the escape decoder's input and output
// words. Depends on bed_pkg for field widths.
interface bed_in_if;
  logic                      valid;
  logic                      ready;
  logic [bed_pkg::BYTE_W-1:0] in_byte;
  logic                      in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface bed_out_if;
  logic                      valid;
  logic                      ready;
  logic [bed_pkg::BYTE_W-1:0] out_byte;
  logic                      out_valid;
  logic                      run_last;
  logic                      stream_end;

  modport source (output valid, output out_byte, output out_valid,
                  output run_last, output stream_end, input ready);
  modport sink   (input valid, input out_byte, input out_valid,
                  input run_last, input stream_end, output ready);
endinterface

### rtl/bed_datapath.sv
// Datapath of the escape decoder: held escape characters, byte counter,
// result list and output register. Depends on bed_pkg.
module bed_datapath #(
  parameter int COUNT_BITS = bed_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bed_pkg::bed_cmd_t             cmd,
  output bed_pkg::bed_stat_t            stat,
  input  logic [bed_pkg::BYTE_W-1:0]    in_byte,
  input  logic                          in_last,
  input  logic                          cfg_we,
  input  logic [bed_pkg::MAX_OUT_W-1:0] cfg_wdata,
  output logic [bed_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_valid,
  output logic                          run_last,
  output logic                          stream_end
);
  import bed_pkg::*;

  localparam int CMP_W = (COUNT_BITS > MAX_OUT_W) ? COUNT_BITS : MAX_OUT_W;

  logic [MAX_OUT_W-1:0]  max_output;
  logic [BYTE_W-1:0]     held [HOLD_DEPTH];
  logic [HOLD_CNT_W-1:0] held_count;
  logic [COUNT_BITS-1:0] emitted_count;
  bed_entry_t            list [LIST_DEPTH];
  logic [LIST_CNT_W-1:0] list_len;
  logic                  list_last;
  logic                  out_full;

  logic [HOLD_CNT_W-1:0] pos, prev_idx;
  logic [4:0]            hx, hp;
  logic                  is_x1, ok, done, fresh, stored, app_c;
  logic [LIST_CNT_W-1:0] pre_len, n_all, n_eff, load_len;
  logic [CMP_W-1:0]      max_w, cap_w, emit_w, lim_w, room_w;
  bed_entry_t            new_list [LIST_DEPTH];

  always_comb begin
    pos      = held_count;
    prev_idx = (pos == '0) ? '0 : pos - 3'd1;
    hx       = hex_digit(in_byte);
    hp       = hex_digit(held[prev_idx]);
    is_x1    = (held[1] == CH_X);

    ok = 1'b0;
    if (pos == 3'd1) begin
      ok = (in_byte == CH_X) || (in_byte == CH_U);
    end else if (pos >= 3'd2) begin
      ok = hx[4] && (is_x1 ? (pos <= X_DONE_POS) : (pos <= U_DONE_POS));
    end
    done   = ok && ((is_x1 && pos == X_DONE_POS) || (held[1] == CH_U && pos == U_DONE_POS));
    fresh  = !ok;
    stored = ok && !done;

    // broken escape or stream end: held characters go out literally first
    pre_len = (!done && (fresh || in_last)) ? pos : '0;
    app_c   = done ? 1'b0 : (fresh ? (in_byte != CH_BSLASH || in_last) : in_last);
    n_all   = done ? 3'd1 : pre_len + {2'b0, app_c};

    max_w  = CMP_W'(max_output);
    cap_w  = CMP_W'({COUNT_BITS{1'b1}});
    emit_w = CMP_W'(emitted_count);
    lim_w  = (max_w < cap_w) ? max_w : cap_w;
    room_w = (emit_w >= lim_w) ? '0 : lim_w - emit_w;
    n_eff  = (room_w < CMP_W'(n_all)) ? LIST_CNT_W'(room_w) : n_all;

    load_len = (n_eff == '0 && in_last) ? 3'd1 : n_eff;

    for (int i = 0; i < LIST_DEPTH; i++) begin
      new_list[i].valid = 1'b1;
      new_list[i].data  = in_byte;
    end
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      if (LIST_CNT_W'(i) < pre_len) begin
        new_list[i].data = held[i];
      end
    end
    if (done) begin
      new_list[0].data = {hp[3:0], hx[3:0]};
    end
    // bare end marker
    if (n_eff == '0) begin
      new_list[0].data  = '0;
      new_list[0].valid = 1'b0;
    end

    stat.list_nz  = (list_len != '0);
    stat.list_one = (list_len == 3'd1);
    stat.load_nz  = (load_len != '0);
    stat.out_full = out_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_output    <= MAX_OUT_RESET;
      held_count    <= '0;
      emitted_count <= '0;
      list_len      <= '0;
      out_full      <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_output <= cfg_wdata;
      end
      if (cmd.load) begin
        if (in_last) begin
          held_count    <= '0;
          emitted_count <= '0;
        end else begin
          emitted_count <= emitted_count + COUNT_BITS'(n_eff);
          if (stored) begin
            held_count <= pos + 3'd1;
          end else if (in_byte == CH_BSLASH && fresh) begin
            held_count <= 3'd1;
          end else begin
            held_count <= '0;
          end
        end
        list_len <= load_len;
      end else if (cmd.pop) begin
        list_len <= list_len - 3'd1;
      end
      if (cmd.pop) begin
        out_full <= 1'b1;
      end else if (cmd.take) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (stored) begin
        held[pos] <= in_byte;
      end else if (fresh) begin
        held[0] <= in_byte;
      end
      list      <= new_list;
      list_last <= in_last;
    end else if (cmd.pop) begin
      // advance the list by one word
      for (int i = 0; i < LIST_DEPTH - 1; i++) begin
        list[i] <= list[i+1];
      end
    end
    if (cmd.pop) begin
      out_byte   <= list[0].data;
      out_valid  <= list[0].valid;
      run_last   <= (list_len == 3'd1);
      stream_end <= (list_len == 3'd1) && list_last;
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= HOLD_CNT_W'(HOLD_DEPTH))
    else $error("held_count beyond hold depth");

  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    list_len <= LIST_CNT_W'(LIST_DEPTH))
    else $error("result list overflow");

  a_stream_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.load && in_last |=> emitted_count == '0 && held_count == '0)
    else $error("stream state not cleared at stream end");

  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> list_len != '0)
    else $error("pop from empty result list");

endmodule

### rtl/bed_ctrl.sv
// Controller of the escape decoder: input acceptance and draining of the
// result list into the output register. Depends on bed_pkg.
module bed_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  input  bed_pkg::bed_stat_t stat,
  output bed_pkg::bed_cmd_t  cmd
);
  import bed_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } bed_state_t;

  bed_state_t state, state_next;

  always_comb begin
    cmd.take = stat.out_full && out_ready;
    cmd.pop  = (state == ST_DRAIN) && (!stat.out_full || out_ready);
    // take the next word in the cycle the last queued word leaves
    in_ready = !rst && ((state == ST_IDLE) || (stat.list_one && cmd.pop));
    cmd.load = in_valid && in_ready;

    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load && stat.load_nz) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (cmd.load) begin
          state_next = stat.load_nz ? ST_DRAIN : ST_IDLE;
        end else if (cmd.pop && stat.list_one) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_state_tracks_list: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) == stat.list_nz)
    else $error("controller state out of step with result list");

endmodule

### rtl/backslash_escape_decoder.sv
// Backslash escape decoder: \xHH gives one byte, \uHHHH gives the low byte of
// the value, everything else passes through; a broken escape is replayed
// literally and a stream end flushes held characters, with a bare end marker
// if nothing else goes out. A new input word is taken while idle or as the last
// result word of the one before moves to the output register, so plain text runs
// at one byte per cycle while the output does not stall. A broken escape yields
// up to six result words, which drain one word per cycle into the output register
// unless it is stalled. Top level; uses bed_pkg, bed_if, bed_ctrl and bed_datapath.
module backslash_escape_decoder #(
  parameter int COUNT_BITS = bed_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bed_pkg::MAX_OUT_W-1:0] cfg_wdata,
  bed_in_if.sink                        din,
  bed_out_if.source                     dout
);
  import bed_pkg::*;

  bed_cmd_t  cmd;
  bed_stat_t stat;

  bed_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_ready (dout.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bed_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_byte    (din.in_byte),
    .in_last    (din.in_last),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_byte   (dout.out_byte),
    .out_valid  (dout.out_valid),
    .run_last   (dout.run_last),
    .stream_end (dout.stream_end)
  );

  assign dout.valid = stat.out_full;

endmodule
